// ----- rtl/pcrc_pkg.sv -----
// Package: shared types, constants and the byte-wide CRC step for the cksum engine.
package pcrc_pkg;

  localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INVERT = 32'hFFFF_FFFF;

  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] checksum;
    logic [63:0] byte_length;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic data_en;    // fold a message byte, bump the count
    logic len_start;  // copy count into the length shifter
    logic len_step;   // fold the low length byte, shift right by 8
    logic emit;       // load the output register, clear crc and count
  } pcrc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rem_zero;   // no length bytes left
    logic slot_free;  // output register empty or being taken
  } pcrc_stat_t;

  // MSB-first CRC over one byte, eight shift/xor steps
  function automatic logic [31:0] crc_feed_byte(input logic [31:0] crc,
                                                input logic [7:0]  b);
    logic [31:0] r;
    r = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if (r[31]) begin
        r = {r[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[30:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/pcrc_dp.sv -----
// Datapath: CRC and count registers, length shifter and output register.
module pcrc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pcrc_pkg::pcrc_cmd_t cmd,
  output pcrc_pkg::pcrc_stat_t stat,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output pcrc_pkg::out_word_t out_word
);

  logic [31:0]         crc_r, crc_nxt;
  logic [63:0]         count_r, count_nxt;
  logic [63:0]         rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  pcrc_pkg::out_word_t out_word_r, out_word_nxt;

  always_comb begin
    crc_nxt       = crc_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.data_en) begin
      crc_nxt   = pcrc_pkg::crc_feed_byte(crc_r, data_byte);
      count_nxt = count_r + 64'd1;
    end
    if (cmd.len_start) begin
      rem_nxt = count_r;
    end
    if (cmd.len_step) begin
      crc_nxt = pcrc_pkg::crc_feed_byte(crc_r, rem_r[7:0]);
      rem_nxt = {8'h00, rem_r[63:8]};
    end
    if (cmd.emit) begin
      out_word_nxt.checksum    = crc_r ^ pcrc_pkg::CRC_INVERT;
      out_word_nxt.byte_length = count_r;
      out_valid_nxt            = 1'b1;
      crc_nxt                  = 32'h0;
      count_nxt                = 64'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= 32'h0;
      count_r     <= 64'h0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    out_word_r <= out_word_nxt;
  end

  assign stat.rem_zero  = (rem_r == 64'h0);
  assign stat.slot_free = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;

endmodule

// ----- rtl/pcrc_ctrl.sv -----
// Controller: sequences data bytes, length append and result hand-off.
module pcrc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_stall,
  input  pcrc_pkg::pcrc_stat_t stat,
  output pcrc_pkg::pcrc_cmd_t  cmd
);

  typedef enum logic {
    ST_DATA,
    ST_LEN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_DATA);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_DATA: begin
        if (accept) begin
          if (in_op == pcrc_pkg::OP_FINISH) begin
            cmd.len_start = 1'b1;
            state_nxt     = ST_LEN;
          end else begin
            cmd.data_en = 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (!stat.rem_zero) begin
          cmd.len_step = 1'b1;
        end else if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_DATA;
        end
      end
      default: begin
        state_nxt = ST_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DATA;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/posix_cksum_crc32.sv -----
// Top level: POSIX cksum engine, controller plus datapath.
//
//  channel | ports                        | word
//  --------+------------------------------+--------------------------------
//  input   | in_valid, in_stall, in_word  | op, data_byte
//  output  | out_valid, out_stall, out_word | checksum, byte_length
//
// Data words are taken one per cycle while in_stall is low; the CRC byte step is
// combinational. A finish word stalls the input while the length is appended
// one byte per cycle (0 to 8 bytes), then the output register is loaded, once
// the previous result is no longer held by out_stall.
// A held result does not block data words of the next message.
// Reset (rst_n low, synchronous) clears CRC, count, state and out_valid.
module posix_cksum_crc32 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcrc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pcrc_pkg::out_word_t out_word
);

  pcrc_pkg::pcrc_cmd_t  cmd;
  pcrc_pkg::pcrc_stat_t stat;

  // sequencing
  pcrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // CRC, count, length shifter, output register
  pcrc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .data_byte (in_word.data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // a result leaves only once the length is fully folded in
  a_emit_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.rem_zero)
    else $error("result emitted with length bytes pending");

  // an emitted result shows up on the output next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  // a finish word closes the input until its result is loaded
  a_finish_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_word.op == pcrc_pkg::OP_FINISH)) |=> in_stall)
    else $error("input open during length append");

  // never more than one command at once
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

// ----- tb/posix_cksum_crc32_tb.sv -----
// Testbench for the POSIX cksum engine: directed and random messages against a checksum tracker.
`timescale 1ns / 100ps

module posix_cksum_crc32_tb;

  // The run's cycle budget covers idle gaps, length append and output stall;
  // this limit leaves several times the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned RAND_WORDS  = 1500;
  localparam int unsigned QUIET_AFTER = 1300;  // no idling from here on
  localparam int unsigned DRAIN_WAIT  = 12;    // extra wait after the last expected sum

  // Tracks the running CRC and byte count of the open message and queues
  // the checksum each finish word should produce.
  class cksum_checker;
    logic [31:0]         crc_table [256];
    logic [31:0]         run_crc;
    logic [63:0]         run_count;
    pcrc_pkg::out_word_t expected_sums [$];
    int unsigned         mismatches;
    int unsigned         sums_seen;

    function new();
      logic [31:0] t;
      for (int i = 0; i < 256; i++) begin
        t = 32'(i) << 24;
        for (int k = 0; k < 8; k++) begin
          t = t[31] ? ((t << 1) ^ pcrc_pkg::CRC_POLY) : (t << 1);
        end
        crc_table[i] = t;
      end
      run_crc    = '0;
      run_count  = '0;
      mismatches = 0;
      sums_seen  = 0;
    endfunction

    // table-driven, MSB first
    function logic [31:0] fold_byte(logic [31:0] crc, logic [7:0] b);
      return {crc[23:0], 8'h00} ^ crc_table[crc[31:24] ^ b];
    endfunction

    function void take_word(pcrc_pkg::in_word_t w);
      logic [31:0]         c;
      logic [63:0]         rem;
      pcrc_pkg::out_word_t sum;
      if (w.op == pcrc_pkg::OP_DATA) begin
        run_crc   = fold_byte(run_crc, w.data_byte);
        run_count = run_count + 64'd1;
      end else begin
        // length goes in LSB first, only up to its highest nonzero byte;
        // data_byte on a finish word plays no part
        c   = run_crc;
        rem = run_count;
        while (rem != 64'd0) begin
          c   = fold_byte(c, rem[7:0]);
          rem = rem >> 8;
        end
        sum.checksum    = c ^ pcrc_pkg::CRC_INVERT;
        sum.byte_length = run_count;
        expected_sums.push_back(sum);
        run_crc   = '0;
        run_count = '0;
      end
    endfunction

    function int unsigned pending();
      return expected_sums.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task match_sum(pcrc_pkg::out_word_t got);
      pcrc_pkg::out_word_t want;
      sums_seen++;
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected word checksum=%08h length=%0d",
                                  got.checksum, got.byte_length));
      end else begin
        want = expected_sums.pop_front();
        if (got.checksum !== want.checksum) begin
          report_mismatch($sformatf("checksum %08h, want %08h (length %0d)",
                                    got.checksum, want.checksum, want.byte_length));
        end
        if (got.byte_length !== want.byte_length) begin
          report_mismatch($sformatf("byte_length %0d, want %0d",
                                    got.byte_length, want.byte_length));
        end
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  pcrc_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  pcrc_pkg::out_word_t out_word;

  cksum_checker sb;
  int unsigned  cycle_count = 0;
  int unsigned  words_sent = 0;
  int unsigned  longest_msg = 0;
  bit           stall_quiet = 1'b0;

  posix_cksum_crc32 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sums still expected",
               cycle_count, sb.pending());
      $display("posix_cksum_crc32 test failed");
      $finish;
    end
  end

  // Monitor both channels on the same edge the handshake completes.
  // Values read here are the pre-edge ones, so no ordering race.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.take_word(in_word);
      end
      if (out_valid && !out_stall) begin
        sb.match_sum(out_word);
      end
    end
  end

  // Receiver back-pressure: random stall bursts, off during
  // the quiet tail of the run.
  initial begin
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!stall_quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(input pcrc_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic idle_input(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_word('{op: pcrc_pkg::OP_DATA, data_byte: b});
  endtask

  task automatic send_finish(input logic [7:0] b);
    send_word('{op: pcrc_pkg::OP_FINISH, data_byte: b});
  endtask

  // mostly uniform bytes, with the edge values mixed in
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // n data words then a finish; gaps land before any word, including the
  // finish, so idling hits every phase of a message.
  task automatic send_message(input int unsigned n, input bit allow_idle);
    pcrc_pkg::in_word_t w;
    for (int unsigned i = 0; i <= n; i++) begin
      if (allow_idle && $urandom_range(0, 7) == 0) begin
        idle_input($urandom_range(1, 18));
      end
      w.op        = (i == n) ? pcrc_pkg::OP_FINISH : pcrc_pkg::OP_DATA;
      w.data_byte = pick_byte();
      send_word(w);
    end
    if (n > longest_msg) longest_msg = n;
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    bit          quiet;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    sb = new();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // empty message: no length bytes, checksum all ones; data on finish ignored
    send_finish(8'hFF);
    send_finish(8'h00);
    // single-byte extremes
    send_data(8'h00);
    send_finish(8'hA5);
    send_data(8'hFF);
    send_finish(8'h5A);
    // top bit set/clear patterns
    send_data(8'h80);
    send_data(8'h01);
    send_data(8'h7F);
    send_data(8'hFE);
    send_data(8'h55);
    send_data(8'hAA);
    send_finish(8'hFF);
    // "123"
    send_data(8'h31);
    send_data(8'h32);
    send_data(8'h33);
    send_finish(8'h00);

    // --- random ---
    // Lengths: mostly short, some medium, a few past 255 so the length
    // append takes two bytes. Count wrap at 2^64 is out of reach here.
    while (words_sent < RAND_WORDS) begin
      quiet       = (words_sent >= QUIET_AFTER);
      stall_quiet = quiet;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        n = $urandom_range(200, 300);
      end else if (pick < 15) begin
        n = $urandom_range(25, 120);
      end else begin
        n = $urandom_range(0, 24);
      end
      // some messages go through with no input gaps at all
      send_message(n, !quiet && $urandom_range(0, 3) != 0);
    end

    // --- drain ---
    in_valid <= 1'b0;
    stall_quiet = 1'b1;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d sums never arrived", sb.pending()));
    end

    $display("Ran %0d words in %0d messages, longest %0d data bytes, in %0d cycles",
             words_sent, sb.sums_seen, longest_msg, cycle_count);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("posix_cksum_crc32 test passed");
    end else begin
      $display("posix_cksum_crc32 test failed");
    end
    $finish;
  end

endmodule
